FILE: hw/rtl/mad_pkg.sv
// Shared constants, types, rounding and saturation helpers for the modulated allpass delay.
package mad_pkg;

    // Storage and sample format
    localparam int DEPTH       = 4096;
    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;

    // Gain and register formats
    localparam int GAIN_W     = 16;
    localparam int GAIN_SHIFT = 15;
    localparam int MOD_W      = 20;
    localparam int FIX_W      = 12;
    localparam int CFG_W      = 20;
    localparam int CFG_IDX_W  = 3;

    // Datapath widths
    localparam int OPB_W  = SAMPLE_BITS + 1;
    localparam int PROD_W = GAIN_W + OPB_W;
    localparam int WIDE_W = PROD_W + 2;

    localparam logic signed [WIDE_W-1:0] SMP_MAX =
        WIDE_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [WIDE_W-1:0] SMP_MIN = -SMP_MAX - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] ROUND_HALF =
        WIDE_W'(64'sd1 <<< (GAIN_SHIFT - 1));

    // Register reset values
    localparam logic signed [GAIN_W-1:0] FEED_FORWARD_RST = GAIN_W'(32767);
    localparam logic [MOD_W-1:0]         MOD_DELAY_RST    = MOD_W'(1 << FRAC_BITS);
    localparam logic [FIX_W-1:0]         FIXED_DELAY_RST  = FIX_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FEEDBACK_GAIN     = 3'd0,
        CFG_BLEND_GAIN        = 3'd1,
        CFG_FEED_FORWARD_GAIN = 3'd2,
        CFG_MOD_DELAY         = 3'd3,
        CFG_FIXED_DELAY       = 3'd4
    } mad_cfg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_RD_MOD,
        ST_RD_FIX,
        ST_TAP,
        ST_MUL_FF,
        ST_OUT
    } mad_state_t;

    typedef enum logic [1:0] {
        MUL_FB,
        MUL_BLEND,
        MUL_AP,
        MUL_FF
    } mad_mul_t;

    typedef enum logic {
        RD_MOD,
        RD_FIX
    } mad_rd_t;

    typedef struct packed {
        logic     load_in;
        logic     mul_en;
        mad_mul_t mul_sel;
        logic     store_sum;
        logic     clear_wr;
        mad_rd_t  rd_sel;
        logic     capture_rd;
        logic     acc_load;
        logic     tap_upd;
        logic     out_load;
    } mad_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic clear_last;
    } mad_status_t;

    // Round to nearest, ties toward plus infinity, after dropping GAIN_SHIFT bits
    function automatic logic signed [WIDE_W-1:0] round_drop(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [WIDE_W-1:0] t;
        t = v + ROUND_HALF;
        return t >>> GAIN_SHIFT;
    endfunction

    // Clamp to the sample range
    function automatic logic signed [SAMPLE_BITS-1:0] saturate(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [WIDE_W-1:0] c;
        if (v > SMP_MAX)
            c = SMP_MAX;
        else if (v < SMP_MIN)
            c = SMP_MIN;
        else
            c = v;
        return c[SAMPLE_BITS-1:0];
    endfunction

endpackage

FILE: hw/rtl/mad_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mad_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/mad_alpha_div.sv
// Bit-serial divider that derives the allpass coefficient from the fractional delay.
module mad_alpha_div
    import mad_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [FRAC_BITS-1:0]     frac,
    output logic                     busy,
    output logic signed [GAIN_W-1:0] alpha
);

    localparam int D_W  = FRAC_BITS + 1;
    localparam int DEN_W = FRAC_BITS + 2;
    localparam int QB   = GAIN_SHIFT + 1;
    localparam int NW   = FRAC_BITS + GAIN_SHIFT + 2;
    localparam int CNT_W = $clog2(QB + 1);
    localparam logic [D_W-1:0] ONE = D_W'(1 << FRAC_BITS);

    logic [D_W-1:0]   d_adj;
    logic             neg;
    logic [D_W-1:0]   mag;
    logic [DEN_W-1:0] den;
    logic [NW-1:0]    dividend;

    logic [DEN_W-1:0]        den_reg;
    logic [DEN_W-1:0]        rem_reg;
    logic [DEN_W-1:0]        rem_next;
    logic [QB-1:0]           quo_reg;
    logic [QB-1:0]           quo_next;
    logic                    neg_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic                    busy_reg;
    logic                    busy_next;
    logic signed [GAIN_W-1:0] alpha_reg;
    logic signed [GAIN_W-1:0] alpha_next;
    logic [DEN_W:0]          trial;
    logic                    qbit;

    // Borrow one sample when the fraction is below one half
    always_comb
    begin
        d_adj = frac[FRAC_BITS-1] ? D_W'(frac) : D_W'(frac) + ONE;
        neg   = d_adj > ONE;
        mag   = neg ? (d_adj - ONE) : (ONE - d_adj);
        den   = DEN_W'(ONE) + DEN_W'(d_adj);
        dividend = (NW'(mag) << GAIN_SHIFT) + NW'(den >> 1);
    end

    // One restoring step per cycle
    always_comb
    begin
        trial = {rem_reg, quo_reg[QB-1]};
        qbit  = trial >= {1'b0, den_reg};
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        alpha_next = alpha_reg;
        if (start)
        begin
            rem_next  = DEN_W'(dividend[NW-1:QB]);
            quo_next  = dividend[QB-1:0];
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            quo_next = {quo_reg[QB-2:0], qbit};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(QB - 1))
            begin
                busy_next  = 1'b0;
                alpha_next = neg_reg ? -GAIN_W'({quo_reg[QB-2:0], qbit})
                                     : GAIN_W'({quo_reg[QB-2:0], qbit});
            end
        end
    end

    // Hold operands for the run; step remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            neg_reg <= neg;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // Control and coefficient state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
            alpha_reg <= '0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            busy_reg  <= busy_next;
            alpha_reg <= alpha_next;
        end
    end

    assign busy  = busy_reg;
    assign alpha = alpha_reg;

endmodule

FILE: hw/rtl/mad_datapath.sv
// Datapath: configuration registers, delay store, shared multiplier and allpass state.
module mad_datapath
    import mad_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic [SAMPLE_BITS-1:0] sample_in,
    input  mad_cmd_t               cmd,
    output mad_status_t            status,
    output logic [SAMPLE_BITS-1:0] sample_out
);

    // Configuration
    logic signed [GAIN_W-1:0] fb_gain_reg;
    logic signed [GAIN_W-1:0] blend_gain_reg;
    logic signed [GAIN_W-1:0] ff_gain_reg;
    logic [MOD_W-1:0]         mod_delay_reg;
    logic [FIX_W-1:0]         fixed_delay_reg;

    // Item state
    logic [ADDR_W-1:0]             wp_reg;
    logic signed [SAMPLE_BITS-1:0] ap_in_reg;
    logic signed [SAMPLE_BITS-1:0] ap_out_reg;
    logic signed [SAMPLE_BITS-1:0] fixed_tap_reg;

    // Working registers
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [SAMPLE_BITS-1:0] sum_reg;
    logic signed [SAMPLE_BITS-1:0] rd_reg;
    logic signed [SAMPLE_BITS-1:0] tap_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [PROD_W-1:0]      acc_reg;
    logic [SAMPLE_BITS-1:0]        out_reg;

    logic                          div_start;
    logic                          div_busy;
    logic signed [GAIN_W-1:0]      alpha;

    logic [ADDR_W-1:0]             mod_addr;
    logic [ADDR_W-1:0]             fix_addr;
    logic [ADDR_W-1:0]             raddr;
    logic                          ram_we;
    logic [SAMPLE_BITS-1:0]        ram_wdata;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic signed [SAMPLE_BITS-1:0] rd_s;

    logic signed [GAIN_W-1:0]      mul_a;
    logic signed [OPB_W-1:0]       mul_b;
    logic signed [SAMPLE_BITS-1:0] sum_val;
    logic signed [SAMPLE_BITS-1:0] tap_val;
    logic signed [SAMPLE_BITS-1:0] out_val;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_gain_reg     <= '0;
            blend_gain_reg  <= '0;
            ff_gain_reg     <= FEED_FORWARD_RST;
            mod_delay_reg   <= MOD_DELAY_RST;
            fixed_delay_reg <= FIXED_DELAY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FEEDBACK_GAIN:     fb_gain_reg     <= cfg_data[GAIN_W-1:0];
                CFG_BLEND_GAIN:        blend_gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_FEED_FORWARD_GAIN: ff_gain_reg     <= cfg_data[GAIN_W-1:0];
                CFG_MOD_DELAY:         mod_delay_reg   <= cfg_data[MOD_W-1:0];
                CFG_FIXED_DELAY:       fixed_delay_reg <= cfg_data[FIX_W-1:0];
                default:               ;
            endcase
        end
    end

    // Recompute the coefficient whenever the modulated delay changes
    assign div_start = cfg_we && (cfg_index == CFG_MOD_DELAY);

    mad_alpha_div u_alpha_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .frac  (cfg_data[FRAC_BITS-1:0]),
        .busy  (div_busy),
        .alpha (alpha)
    );

    // Tap addresses relative to the next write position
    assign mod_addr = wp_reg - ADDR_W'(mod_delay_reg >> FRAC_BITS)
                    + ADDR_W'(!mod_delay_reg[FRAC_BITS-1]);
    assign fix_addr = wp_reg - ADDR_W'(fixed_delay_reg);
    assign raddr    = (cmd.rd_sel == RD_MOD) ? mod_addr : fix_addr;

    // Input sum with feedback, written to the store
    assign sum_val   = saturate(round_drop((WIDE_W'(x_reg) <<< GAIN_SHIFT)
                                           - WIDE_W'(prod_reg)));
    assign ram_we    = cmd.store_sum || cmd.clear_wr;
    assign ram_wdata = cmd.clear_wr ? '0 : sum_val;

    mad_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    assign rd_s = $signed(ram_rdata);

    // Shared multiplier operand select
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_FB:
            begin
                mul_a = fb_gain_reg;
                mul_b = OPB_W'(fixed_tap_reg);
            end
            MUL_BLEND:
            begin
                mul_a = blend_gain_reg;
                mul_b = OPB_W'(sum_reg);
            end
            MUL_AP:
            begin
                mul_a = alpha;
                mul_b = OPB_W'(rd_s) - OPB_W'(ap_out_reg);
            end
            MUL_FF:
            begin
                mul_a = ff_gain_reg;
                mul_b = OPB_W'(tap_reg);
            end
            default:
            begin
                mul_a = fb_gain_reg;
                mul_b = OPB_W'(fixed_tap_reg);
            end
        endcase
    end

    // Allpass tap and output mix
    assign tap_val = saturate(round_drop(WIDE_W'(prod_reg)) + WIDE_W'(ap_in_reg));
    assign out_val = saturate(round_drop(WIDE_W'(acc_reg) + WIDE_W'(prod_reg)));

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            x_reg <= $signed(sample_in);
        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
        if (cmd.store_sum)
            sum_reg <= sum_val;
        if (cmd.capture_rd)
            rd_reg <= rd_s;
        if (cmd.acc_load)
            acc_reg <= prod_reg;
        if (cmd.tap_upd)
            tap_reg <= tap_val;
        if (cmd.out_load)
            out_reg <= out_val;
    end

    // Write pointer and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            ap_in_reg     <= '0;
            ap_out_reg    <= '0;
            fixed_tap_reg <= '0;
        end
        else
        begin
            if (ram_we)
                wp_reg <= wp_reg + ADDR_W'(1);
            if (cmd.tap_upd)
            begin
                ap_in_reg     <= rd_reg;
                ap_out_reg    <= tap_val;
                fixed_tap_reg <= rd_s;
            end
        end
    end

    assign status.div_busy   = div_busy;
    assign status.clear_last = (wp_reg == ADDR_W'(DEPTH - 1));
    assign sample_out        = out_reg;

endmodule

FILE: hw/rtl/mad_ctrl.sv
// Controller: clearing pass, per-item sequence and output handshake.
module mad_ctrl
    import mad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  mad_status_t status,
    output mad_cmd_t    cmd
);

    mad_state_t state_reg;
    mad_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && !status.div_busy;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (status.clear_last) state_next = ST_IDLE;
            ST_IDLE:   if (in_ready && in_valid) state_next = ST_WRITE;
            ST_WRITE:  state_next = ST_RD_MOD;
            ST_RD_MOD: state_next = ST_RD_FIX;
            ST_RD_FIX: state_next = ST_TAP;
            ST_TAP:    state_next = ST_MUL_FF;
            ST_MUL_FF: state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = MUL_FB;
        cmd.rd_sel     = RD_MOD;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.load_in = in_ready && in_valid;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_FB;
            end
            ST_WRITE:
            begin
                cmd.store_sum = 1'b1;
            end
            ST_RD_MOD:
            begin
                cmd.rd_sel  = RD_MOD;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_BLEND;
            end
            ST_RD_FIX:
            begin
                cmd.rd_sel     = RD_FIX;
                cmd.capture_rd = 1'b1;
                cmd.acc_load   = 1'b1;
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = MUL_AP;
            end
            ST_TAP:
            begin
                cmd.tap_upd = 1'b1;
            end
            ST_MUL_FF:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_FF;
            end
            ST_OUT:
            begin
                cmd.out_load = out_free;
                if (out_free)
                    out_valid_next = 1'b1;
            end
            default:
            begin
                cmd.clear_wr = 1'b0;
            end
        endcase
    end

    // State and output flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: hw/rtl/modulated_allpass_delay_core.sv
// Top level of the modulated allpass-interpolated fractional delay line.
//
// Usage:
//   s_axis carries one signed sample per transfer in tdata; m_axis returns one
//   mixed, saturated sample per input transfer, in order.
//   The cfg port writes feedback, blend and feed-forward gains, the modulated
//   delay (8 fraction bits) and the fixed delay; write only while no sample is
//   in flight.
// Sequencing:
//   Each sample is processed through to the output register before the next
//   sample is taken; the sequence is set by the single shared multiplier and
//   the one read port of the delay RAM.
//   A write of the modulated delay starts a serial divide for the
//   allpass coefficient; s_axis_tready stays low until it completes.
// Reset:
//   rst_n resets control, configuration and filter state; the delay RAM is
//   then zeroed one entry per cycle, all 4096 entries, with s_axis_tready low.
// Back-pressure:
//   The result waits in the output register while m_axis_tready is low; the
//   next sample is still taken and processed and holds before its final step.
module modulated_allpass_delay_core
    import mad_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [DATA_W-1:0]    s_axis_tdata,   // [15:0] sample_in
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [DATA_W-1:0]    m_axis_tdata,   // [15:0] sample_out
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    mad_cmd_t               cmd;
    mad_status_t            status;
    logic [SAMPLE_BITS-1:0] sample_out;

    mad_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    mad_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_in  (s_axis_tdata[SAMPLE_BITS-1:0]),
        .cmd        (cmd),
        .status     (status),
        .sample_out (sample_out)
    );

    // Pad the sample to whole bytes
    assign m_axis_tdata = DATA_W'(sample_out);

endmodule
